// ----- rtl/tdpt_pkg.sv -----
package tdpt_pkg;

   // width of the result stream payload: is_prime padded to a byte
   localparam int RSP_DATA_W = 8;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;       // capture a new value, restart divisor at two
      logic div_start;  // clear remainder, point at the top value bit
      logic div_step;   // one restoring remainder step
      logic next_div;   // advance divisor and its square
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic below_two;  // value is zero or one
      logic square_gt;  // divisor squared exceeds value
      logic last_bit;   // current step consumes the lowest value bit
      logic rem_zero;   // remainder is zero
   } status_type;

endpackage

// ----- rtl/tdpt_datapath.sv -----
module tdpt_datapath
   import tdpt_pkg::*;
#(
   parameter int VALUE_WIDTH = 31
) (
   input  logic                   clock,
   input  logic [VALUE_WIDTH-1:0] value,
   input  cmd_type                cmd,
   output status_type             status
);

   localparam int CNT_W = $clog2(VALUE_WIDTH);
   localparam int SQ_W  = VALUE_WIDTH + 2;

   logic [VALUE_WIDTH-1:0] value_ff,   value_in;
   logic [VALUE_WIDTH-1:0] divisor_ff, divisor_in;
   logic [SQ_W-1:0]        square_ff,  square_in;
   logic [VALUE_WIDTH:0]   rem_ff,     rem_in;
   logic [CNT_W-1:0]       bit_cnt_ff, bit_cnt_in;

   logic [VALUE_WIDTH:0]   shifted;
   logic [VALUE_WIDTH:0]   diff;

   // restoring remainder step: shift in the next value bit, subtract if it fits
   assign shifted = {rem_ff[VALUE_WIDTH-1:0], value_ff[bit_cnt_ff]};
   assign diff    = shifted - {1'b0, divisor_ff};

   // next-state logic for the datapath registers
   always_comb begin
      value_in   = value_ff;
      divisor_in = divisor_ff;
      square_in  = square_ff;
      rem_in     = rem_ff;
      bit_cnt_in = bit_cnt_ff;
      if (cmd.load) begin
         value_in   = value;
         divisor_in = VALUE_WIDTH'(2);
         square_in  = SQ_W'(4);
      end
      if (cmd.div_start) begin
         rem_in     = '0;
         bit_cnt_in = CNT_W'(VALUE_WIDTH - 1);
      end
      if (cmd.div_step) begin
         rem_in     = (shifted >= {1'b0, divisor_ff}) ? diff : shifted;
         bit_cnt_in = bit_cnt_ff - CNT_W'(1);
      end
      if (cmd.next_div) begin
         // (d+1)^2 = d^2 + 2d + 1
         divisor_in = divisor_ff + VALUE_WIDTH'(1);
         square_in  = square_ff + {1'b0, divisor_ff, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      divisor_ff <= divisor_in;
      square_ff  <= square_in;
      rem_ff     <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
   end

   // status back to the controller
   assign status.below_two = (value_ff[VALUE_WIDTH-1:1] == '0);
   assign status.square_gt = (square_ff > {2'b00, value_ff});
   assign status.last_bit  = (bit_cnt_ff == '0);
   assign status.rem_zero  = (rem_ff == '0);

endmodule

// ----- rtl/tdpt_ctrl.sv -----
module tdpt_ctrl
   import tdpt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_prime,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [2:0] {
      IDLE,
      CHECK,
      DIVIDE,
      TEST,
      DONE
   } state_type;

   state_type state_ff, state_in;
   logic      result_ff, result_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      is_prime_ff, is_prime_in;
   logic      slot_free;

   // the output register can take a result when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // datapath commands follow the state
   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == IDLE) && req_valid;
      cmd.div_start = (state_ff == CHECK) && !status.below_two && !status.square_gt;
      cmd.div_step  = (state_ff == DIVIDE);
      cmd.next_div  = (state_ff == TEST) && !status.rem_zero;
   end

   // next state and registered outputs
   always_comb begin
      state_in     = state_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      is_prime_in  = is_prime_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               state_in = CHECK;
            end
         end
         CHECK: begin
            priority if (status.below_two) begin
               result_in = 1'b0;
               state_in  = DONE;
            end else if (status.square_gt) begin
               result_in = 1'b1;
               state_in  = DONE;
            end else begin
               state_in = DIVIDE;
            end
         end
         DIVIDE: begin
            if (status.last_bit) begin
               state_in = TEST;
            end
         end
         TEST: begin
            if (status.rem_zero) begin
               result_in = 1'b0;
               state_in  = DONE;
            end else begin
               state_in = CHECK;
            end
         end
         DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               is_prime_in  = result_ff;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      result_ff   <= result_in;
      is_prime_ff <= is_prime_in;
   end

   assign req_ready    = (state_ff == IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = is_prime_ff;

endmodule

// ----- rtl/trial_division_prime_test_core.sv -----
// trial division primality test
//
// req channel: one transfer carries the value to test in req_tdata.
// rsp channel: one transfer per request, is_prime in rsp_tdata bit 0
// (zero and one report as not prime).
//
// each candidate divisor d = 2, 3, ... takes one bound check of d*d
// against the value, VALUE_WIDTH steps of the bit-serial restoring
// remainder unit and one zero test. the bound uses a running square, so
// no multiplier is needed.
// one item is in work at a time; req_tready is high only while idle.
//
// the result sits in an output register, so the next request is taken
// while a finished result waits for rsp_tready. a finished test waits for
// that register to drain before it is written.
// reset clears the controller and the output valid; nothing else is kept
// between items.
module trial_division_prime_test_core
   import tdpt_pkg::*;
#(
   parameter int VALUE_WIDTH = 31
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // fields from bit 0: value
   input  logic [((VALUE_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // fields from bit 0: is_prime
   output logic [RSP_DATA_W-1:0]          rsp_tdata
);

   cmd_type    cmd;
   status_type status;
   logic       rsp_is_prime;

   tdpt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_is_prime (rsp_is_prime),
      .cmd          (cmd),
      .status       (status)
   );

   tdpt_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock  (clock),
      .value  (req_tdata[VALUE_WIDTH-1:0]),
      .cmd    (cmd),
      .status (status)
   );

   // pad the result to a byte
   assign rsp_tdata = {{(RSP_DATA_W-1){1'b0}}, rsp_is_prime};

endmodule

// ----- rtl/tdpt_checker.sv -----
module tdpt_checker
   import tdpt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid set after reset");

   // an accepted request makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready held after a request transfer");

   // a new result only appears at the end of a busy period
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready) && req_tready)
      else $error("result appeared without a test in progress");

   // only bit 0 of the result payload carries data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_W-1:1] == '0))
      else $error("padding bits of rsp_tdata set");

endmodule

bind trial_division_prime_test_core tdpt_checker u_tdpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- verif/tb_trial_division_prime_test_core.sv -----
module tb_trial_division_prime_test_core
   import tdpt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_W       = 31;
   localparam int REQ_W         = ((VALUE_W + 7) / 8) * 8;
   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 8;
   // longest quiet stretch is the test of one 31-bit prime
   localparam int STALL_LIMIT   = 6_000_000;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 40;
   localparam int RANDOM_ITEMS  = 77;
   localparam int NUM_DIRECTED  = 23;
   localparam int MAX_ITEMS     = NUM_DIRECTED + RANDOM_ITEMS;

   typedef struct packed {
      logic [REQ_W-1:0] data;
      logic             typed;     // is_prime below is given, not predicted
      logic             is_prime;
   } stim_row_type;

   // directed rows: edge values, squares of primes, padding bit above the field
   localparam stim_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{32'h0000_0000, 1'b1, 1'b0},   // zero
      '{32'h0000_0001, 1'b1, 1'b0},   // one
      '{32'h0000_0002, 1'b1, 1'b1},   // smallest prime
      '{32'h0000_0003, 1'b0, 1'b0},
      '{32'h0000_0004, 1'b0, 1'b0},
      '{32'h0000_0005, 1'b0, 1'b0},
      '{32'h0000_0009, 1'b0, 1'b0},   // divisor squared equals value
      '{32'h0000_000F, 1'b0, 1'b0},
      '{32'h0000_0019, 1'b0, 1'b0},
      '{32'h0000_0031, 1'b0, 1'b0},
      '{32'h0000_0061, 1'b0, 1'b0},
      '{32'h0000_F619, 1'b0, 1'b0},   // 251 squared
      '{32'h0000_FFF1, 1'b0, 1'b0},   // largest 16-bit prime
      '{32'h0001_0000, 1'b0, 1'b0},
      '{32'h000F_4243, 1'b0, 1'b0},   // 1000003
      '{32'h4000_0000, 1'b0, 1'b0},
      '{32'h2AAA_AAAA, 1'b0, 1'b0},
      '{32'h5555_5555, 1'b0, 1'b0},
      '{32'h7FFF_FFFE, 1'b1, 1'b0},
      '{32'h8000_0007, 1'b0, 1'b0},   // padding bit set, value seven
      '{32'h8000_0000, 1'b1, 1'b0},   // padding bit set, value zero
      '{32'hFFFF_FFFE, 1'b0, 1'b0},
      '{32'h7FFF_FFFF, 1'b1, 1'b1}    // largest value, a mersenne prime
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   // fields from bit 0: value
   logic [REQ_W-1:0]   req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   // fields from bit 0: is_prime
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;
   logic        hold_armed = 1'b0;
   logic        hold_done = 1'b0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned failures = 0;
   bit          expected_mem [MAX_ITEMS];
   int unsigned sent_count = 0;
   int unsigned checked_count = 0;
   bit          due_bit;

   trial_division_prime_test_core #(
      .VALUE_WIDTH(VALUE_W)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // trial division over d = 2, 3, ... while d*d <= n, bound kept exact as d <= n/d
   function automatic bit is_prime_by_division(input logic [VALUE_W-1:0] v);
      longint unsigned n;
      longint unsigned d;
      n = 64'(v);
      if (n < 2) return 1'b0;
      for (d = 2; d <= n / d; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // random value, mostly cheap: small ranges, or wide values built with a small factor
   function automatic logic [REQ_W-1:0] draw_value();
      int unsigned      pick;
      int unsigned      factor;
      longint unsigned  v;
      logic [REQ_W-1:0] data;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         v = 64'($urandom_range(0, 1023));
      end else if (pick < 55) begin
         v = 64'($urandom_range(0, 65535));
      end else if (pick < 75) begin
         v = 64'($urandom_range(0, (1 << 22) - 1));
      end else begin
         factor = $urandom_range(2, 2000);
         v = longint'(factor) * $urandom_range(1, 32'h7FFF_FFFF / factor);
      end
      data = '0;
      data[VALUE_W-1:0] = v[VALUE_W-1:0];
      data[REQ_W-1:VALUE_W] = (REQ_W - VALUE_W)'($urandom);
      return data;
   endfunction

   // one request transfer, with an optional gap of random length ahead of it
   task automatic send_value(input logic [REQ_W-1:0] data, input bit typed, input bit given);
      bit want;
      want = typed ? given : is_prime_by_division(data[VALUE_W-1:0]);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      expected_mem[sent_count] = want;
      sent_count++;
   endtask

   // receiver: random back-pressure, plus one long hold-off when armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_armed && !hold_done) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (checked_count == sent_count) begin
            $error("result transfer with no request pending: is_prime %0b", rsp_tdata[0]);
            failures++;
         end else begin
            due_bit = expected_mem[checked_count];
            checked_count++;
            if (rsp_tdata[0] !== due_bit) begin
               $error("is_prime mismatch: expected %0b, actual %0b", due_bit, rsp_tdata[0]);
               failures++;
            end
            if (rsp_tdata[RSP_DATA_W-1:1] !== '0) begin
               $error("rsp_tdata padding mismatch: expected 0, actual %0h",
                      rsp_tdata[RSP_DATA_W-1:1]);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // sender idles less than the receiver
      tx_idle_pct = 27;
      rx_idle_pct <= 51;
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_value(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].is_prime);
      end
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
         send_value(draw_value(), 1'b0, 1'b0);
      end

      // roles swapped
      tx_idle_pct = 51;
      rx_idle_pct <= 27;
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
         send_value(draw_value(), 1'b0, 1'b0);
      end

      // no idling; receiver holds off while quick even values back up the block
      tx_idle_pct = 0;
      rx_idle_pct <= 0;
      hold_armed  <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         send_value(REQ_W'($urandom_range(0, 1023) * 2), 1'b0, 1'b0);
      end
      for (int i = 0; i < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3) - 4; i++) begin
         send_value(draw_value(), 1'b0, 1'b0);
      end
      req_tvalid <= 1'b0;

      // drain outstanding results, then a short quiet window
      while (checked_count != sent_count) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
